### rtl/core/dshoc_pkg.sv
// Shared types and constants for the dual sensor occupancy counter.
// No dependencies; imported by every module of the block.
package dshoc_pkg;

    localparam int SAMPLE_W   = 13;
    localparam int VEL_W      = 12;
    localparam int COUNT_W    = 4;
    localparam int OUT_EVT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 4'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_LOW  = 3'd0,
        REG_LOWER_HIGH = 3'd1,
        REG_UPPER_LOW  = 3'd2,
        REG_UPPER_HIGH = 3'd3,
        REG_CAPACITY   = 3'd4
    } cfg_reg_e;

    // Input item payload, last field in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0]         set_value;
        logic signed [VEL_W-1:0]    top_velocity;
        logic signed [VEL_W-1:0]    bottom_velocity;
        logic signed [SAMPLE_W-1:0] upper_sample;
        logic signed [SAMPLE_W-1:0] lower_sample;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]         capacity;
        logic signed [SAMPLE_W-1:0] upper_high;
        logic signed [SAMPLE_W-1:0] upper_low;
        logic signed [SAMPLE_W-1:0] lower_high;
        logic signed [SAMPLE_W-1:0] lower_low;
    } cfg_t;

    typedef struct packed {
        logic               lower_flag;
        logic               upper_flag;
        logic [COUNT_W-1:0] held;
    } occ_state_t;

    typedef struct packed {
        logic grab_inc;
        logic score_inc;
    } occ_event_t;

endpackage

### rtl/core/dshoc_step.sv
// Single-item update: hysteresis compares and carriage count rules, or a set of the count.
// Depends on dshoc_pkg; used by the top level.
module dshoc_step (
    input  logic                dir_op,
    input  dshoc_pkg::item_t    item,
    input  dshoc_pkg::cfg_t     cfg,
    input  dshoc_pkg::occ_state_t cur,
    output dshoc_pkg::occ_state_t nxt,
    output dshoc_pkg::occ_event_t evt
);
    import dshoc_pkg::*;

    logic bot_fwd;
    logic bot_rev;
    logic top_fwd;
    logic top_rev;
    logic [COUNT_W-1:0] held_mid;

    assign bot_rev = item.bottom_velocity[VEL_W-1];
    assign bot_fwd = !item.bottom_velocity[VEL_W-1] && (|item.bottom_velocity);
    assign top_rev = item.top_velocity[VEL_W-1];
    assign top_fwd = !item.top_velocity[VEL_W-1] && (|item.top_velocity);

    always_comb
    begin
        nxt      = cur;
        evt      = '0;
        held_mid = cur.held;
        if (dir_op == OP_SET)
        begin
            if (item.set_value <= cfg.capacity)
                nxt.held = item.set_value;
        end
        else
        begin
            // lower sensor first
            if (!cur.lower_flag && (item.lower_sample < cfg.lower_low))
            begin
                nxt.lower_flag = 1'b1;
                if (bot_fwd && (cur.held < cfg.capacity))
                begin
                    held_mid     = cur.held + 1'b1;
                    evt.grab_inc = 1'b1;
                end
            end
            else if (cur.lower_flag && (item.lower_sample > cfg.lower_high))
            begin
                nxt.lower_flag = 1'b0;
                if (bot_rev && (cur.held != '0))
                    held_mid = cur.held - 1'b1;
            end
            nxt.held = held_mid;
            if (!cur.upper_flag && (item.upper_sample < cfg.upper_low))
            begin
                nxt.upper_flag = 1'b1;
                if (top_rev && (held_mid < cfg.capacity))
                    nxt.held = held_mid + 1'b1;
            end
            else if (cur.upper_flag && (item.upper_sample > cfg.upper_high))
            begin
                nxt.upper_flag = 1'b0;
                if (top_fwd && (held_mid != '0))
                begin
                    nxt.held      = held_mid - 1'b1;
                    evt.score_inc = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/dual_sensor_hysteresis_occupancy_counter.sv
// Top level of the dual sensor hysteresis occupancy counter.
// Depends on dshoc_pkg and dshoc_step.
//
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    s_tuser = op, s_tdata = item fields
//  m_*       out   m_tvalid/m_tready    m_tdata = counts and flags
//  cfg_*     in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an input
// beat goes through the input register, then the state/result register.
// The state registers double as the result register; an input beat is
// taken while a result waits, and the input stage stalls only when both
// stages are full and m_tready is low. Reset clears all but the input data.
module dual_sensor_hysteresis_occupancy_counter #(
    parameter int EVENT_COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // lower_sample, upper_sample, bottom_velocity, top_velocity, set_value
    input  logic [dshoc_pkg::IN_DATA_W-1:0]     s_tdata,
    // op
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // carriage_count, grabbed_count, scored_count, lower_blocked, upper_blocked
    output logic [dshoc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dshoc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dshoc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dshoc_pkg::*;

    logic                        in_valid_reg;
    logic                        in_op_reg;
    item_t                       in_item_reg;
    logic                        out_valid_reg;
    occ_state_t                  state_reg;
    occ_state_t                  state_next;
    occ_event_t                  evt;
    cfg_t                        cfg_reg;
    logic [EVENT_COUNT_BITS-1:0] grab_reg;
    logic [EVENT_COUNT_BITS-1:0] score_reg;
    logic [31:0]                 grab_wide;
    logic [31:0]                 score_wide;
    logic                        advance;
    logic                        in_beat;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_op_reg   <= s_tuser;
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_low  <= '0;
            cfg_reg.lower_high <= '0;
            cfg_reg.upper_low  <= '0;
            cfg_reg.upper_high <= '0;
            cfg_reg.capacity   <= CAPACITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOWER_LOW:  cfg_reg.lower_low  <= cfg_data;
                REG_LOWER_HIGH: cfg_reg.lower_high <= cfg_data;
                REG_UPPER_LOW:  cfg_reg.upper_low  <= cfg_data;
                REG_UPPER_HIGH: cfg_reg.upper_high <= cfg_data;
                REG_CAPACITY:   cfg_reg.capacity   <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    dshoc_step u_step (
        .dir_op (in_op_reg),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .evt    (evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            grab_reg      <= '0;
            score_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                if (evt.grab_inc)
                    grab_reg <= grab_reg + 1'b1;
                if (evt.score_inc)
                    score_reg <= score_reg + 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign grab_wide  = 32'(grab_reg);
    assign score_wide = 32'(score_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       state_reg.upper_flag,
                       state_reg.lower_flag,
                       score_wide[OUT_EVT_W-1:0],
                       grab_wide[OUT_EVT_W-1:0],
                       state_reg.held};

endmodule

### rtl/core/dshoc_checker.sv
// Port-level checks for the occupancy counter, bound to the top level.
// Depends on dshoc_pkg and dual_sensor_hysteresis_occupancy_counter.
module dshoc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dshoc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dshoc_pkg::*;

    logic out_beat;
    logic [OUT_EVT_W-1:0] grabbed;
    logic [OUT_EVT_W-1:0] scored;
    logic lower_blk;

    assign out_beat  = m_tvalid && m_tready;
    assign grabbed   = m_tdata[19:4];
    assign scored    = m_tdata[35:20];
    assign lower_blk = m_tdata[36];

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // a new result follows an input beat through the input and state registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input beat");

    // grabbed count moves only with a lower blocked edge
    a_grab_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && $past(out_beat) && ($past(lower_blk) == lower_blk)
        |-> grabbed == $past(grabbed))
        else $error("grabbed count moved without lower sensor edge");

    // scored count steps by at most one per beat (or wraps)
    a_score_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && $past(out_beat)
        |-> (scored == $past(scored)) || (scored == $past(scored) + 1'b1)
            || (scored == '0))
        else $error("scored count jumped");

endmodule

bind dual_sensor_hysteresis_occupancy_counter dshoc_checker u_dshoc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
